@@ hw/rtl/aelv_pkg.sv @@
// Shared types and constants for the ADSR envelope level pipeline.
// No dependencies; every other file imports this package.
package aelv_pkg;

  localparam int REG_W      = 24;  // width of a length register
  localparam int DEN_W      = 27;  // divisor width, holds 5 * 24-bit length
  localparam int NUM_W      = 42;  // dividend / remainder width
  localparam int Q_W        = 15;  // quotient and gain width
  localparam int DIV_STEPS  = 3;   // quotient bits resolved per divider stage
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int INDEX_BITS_DEF = 24;

  localparam logic [Q_W-1:0] UNITY_Q14 = 15'd16384;
  localparam logic [Q_W-1:0] PEAK_Q14  = 15'd19661;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_RELEASE = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_ATTACK,
    KIND_DECAY,
    KIND_SUSTAIN,
    KIND_RELEASE,
    KIND_ZERO
  } kind_t;

  // Beat leaving the phase stage
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [REG_W-1:0]   operand;
    logic [DEN_W-1:0]   den;
  } phase_beat_t;

  // Beat travelling through the divider stages
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [NUM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [Q_W-1:0]     quo;
  } div_beat_t;

endpackage

@@ hw/rtl/adsr_envelope_level.sv @@
// ADSR envelope level: one beat in per cycle on start, gain on the result
// ports with gain_valid high for one cycle; busy is always low. A beat
// passes through the input register, phase stage, dividend stage, five
// divider stages of three quotient bits each and the output register.
// The receiver cannot stall, so results must be taken as they appear.
// Depends on aelv_pkg, aelv_phase and aelv_div_step.
module adsr_envelope_level import aelv_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] sample_index,
  input  logic [INDEX_BITS-1:0] note_len,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [REG_W-1:0]      wr_data,
  output logic                  gain_valid,
  output logic [Q_W-1:0]        gain
);

  logic [REG_W-1:0]      attack_len, decay_len, release_len;
  logic                  in_valid;
  logic [INDEX_BITS-1:0] x_q, len_q;
  phase_beat_t           ph;
  div_beat_t             num_beat, num_next;
  div_beat_t             chain [DIV_STAGES+1];
  logic [Q_W-1:0]        gain_next;

  assign busy = 1'b0;

  // Hold the length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len  <= '0;
      decay_len   <= '0;
      release_len <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_ATTACK:  attack_len  <= wr_data;
        REG_DECAY:   decay_len   <= wr_data;
        REG_RELEASE: release_len <= wr_data;
        default: ;
      endcase
    end
  end

  // Register the input beat
  always_ff @(posedge clk) begin
    x_q   <= sample_index;
    len_q <= note_len;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  aelv_phase #(.INDEX_BITS(INDEX_BITS)) u_phase (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .x           (x_q),
    .len         (len_q),
    .attack_len  (attack_len),
    .decay_len   (decay_len),
    .release_len (release_len),
    .beat        (ph)
  );

  // Build the dividend: attack scales by 98304, others by 16384
  always_comb begin
    num_next.valid = ph.valid;
    num_next.kind  = ph.kind;
    num_next.den   = ph.den;
    num_next.quo   = '0;
    if (ph.kind == KIND_ATTACK) begin
      num_next.rem = (NUM_W'(ph.operand) << 16) + (NUM_W'(ph.operand) << 15);
    end else begin
      num_next.rem = NUM_W'(ph.operand) << 14;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_beat <= '0;
    end else begin
      num_beat <= num_next;
    end
  end

  assign chain[0] = num_beat;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    aelv_div_step #(.STAGE(s)) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_beat  (chain[s]),
      .out_beat (chain[s+1])
    );
  end

  // Turn the quotient into a gain
  always_comb begin
    case (chain[DIV_STAGES].kind)
      KIND_ATTACK:  gain_next = chain[DIV_STAGES].quo;
      KIND_DECAY:   gain_next = PEAK_Q14 - chain[DIV_STAGES].quo;
      KIND_SUSTAIN: gain_next = UNITY_Q14;
      KIND_RELEASE: gain_next = UNITY_Q14 - chain[DIV_STAGES].quo;
      default:      gain_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    gain <= gain_next;
    if (rst) begin
      gain_valid <= 1'b0;
    end else begin
      gain_valid <= chain[DIV_STAGES].valid;
    end
  end

endmodule

@@ hw/rtl/aelv_phase.sv @@
// Phase select stage: picks attack, decay, sustain, release or zero and sets up
// the division operands. Depends on aelv_pkg.
module aelv_phase import aelv_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [INDEX_BITS-1:0] x,
  input  logic [INDEX_BITS-1:0] len,
  input  logic [REG_W-1:0]      attack_len,
  input  logic [REG_W-1:0]      decay_len,
  input  logic [REG_W-1:0]      release_len,
  output phase_beat_t           beat
);

  localparam int CW = ((INDEX_BITS > REG_W) ? INDEX_BITS : REG_W) + 1;

  logic [CW-1:0] xe, le, ae, de, re, ad, xr, e, dx;
  phase_beat_t   beat_next;

  // Widen everything so no sum wraps
  always_comb begin
    xe = CW'(x);
    le = CW'(len);
    ae = CW'(attack_len);
    de = CW'(decay_len);
    re = CW'(release_len);
    ad = ae + de;
    xr = xe + re;
    e  = xr - le;
    dx = xe - ae;
  end

  // Test phases in order and pick operand and divisor
  always_comb begin
    beat_next.valid   = in_valid;
    beat_next.kind    = KIND_ZERO;
    beat_next.operand = '0;
    beat_next.den     = DEN_W'(release_len);
    if (xe < ae) begin
      beat_next.kind    = KIND_ATTACK;
      beat_next.operand = xe[REG_W-1:0];
      beat_next.den     = {3'b000, attack_len} + {1'b0, attack_len, 2'b00};
    end else if (xe < ad) begin
      beat_next.kind    = KIND_DECAY;
      beat_next.operand = dx[REG_W-1:0];
      beat_next.den     = {3'b000, decay_len} + {1'b0, decay_len, 2'b00};
    end else if (xr < le) begin
      beat_next.kind    = KIND_SUSTAIN;
    end else if (release_len != '0 && xe < le) begin
      beat_next.kind    = KIND_RELEASE;
      beat_next.operand = e[REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else begin
      beat <= beat_next;
    end
  end

endmodule

@@ hw/rtl/aelv_div_step.sv @@
// One restoring-division stage: resolves DIV_STEPS quotient bits, MSB first.
// Depends on aelv_pkg.
module aelv_div_step import aelv_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  div_beat_t in_beat,
  output div_beat_t out_beat
);

  localparam int HI = Q_W - 1 - STAGE * DIV_STEPS;

  div_beat_t     beat_next;
  logic [NUM_W-1:0] trial;

  // Subtract the shifted divisor where it fits
  always_comb begin
    beat_next = in_beat;
    trial     = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = NUM_W'(in_beat.den) << (HI - i);
      if (beat_next.rem >= trial) begin
        beat_next.rem          = beat_next.rem - trial;
        beat_next.quo[HI - i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat <= '0;
    end else begin
      out_beat <= beat_next;
    end
  end

endmodule

@@ sim/adsr_envelope_level_chk.sv @@
`timescale 1ns / 1ps
// Checker for adsr_envelope_level: shadows the length registers, predicts the gain
// of every accepted beat and compares it with the result strobe. Uses aelv_pkg.
module adsr_envelope_level_chk import aelv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [23:0]      sample_index,
  input  logic [23:0]      note_len,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [REG_W-1:0] wr_data,
  input  logic             gain_valid,
  input  logic [Q_W-1:0]   gain,
  output int               fails,
  output int               pending
);

  logic [REG_W-1:0] attack_q, decay_q, release_q;
  logic [Q_W-1:0]   gain_due[$];

  // Envelope gain at sample x within a note of length l, all compares in 64 bits
  function automatic logic [Q_W-1:0] envelope_gain(logic [23:0] x, logic [23:0] l);
    longint unsigned xs, ls, a, d, r, e;
    xs = x; ls = l; a = attack_q; d = decay_q; r = release_q;
    if (xs < a) return Q_W'((xs * 98304) / (5 * a));
    if (xs < a + d) return PEAK_Q14 - Q_W'(((xs - a) * 16384) / (5 * d));
    if (xs + r < ls) return UNITY_Q14;
    if (r == 0) return '0;
    e = xs + r - ls;
    if (e >= r) return '0;
    return UNITY_Q14 - Q_W'((e * 16384) / r);
  endfunction

  assign pending = gain_due.size();

  always @(posedge clk) begin
    if (rst) begin
      attack_q  <= '0;
      decay_q   <= '0;
      release_q <= '0;
      fails     <= 0;
      gain_due.delete();
    end else begin
      // Predict with the registers as they stand before this edge
      if (start && !busy) gain_due.push_back(envelope_gain(sample_index, note_len));
      // Compare the result beat with the oldest prediction
      if (gain_valid) begin
        if (gain_due.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("chk: gain %0d with nothing outstanding", gain);
        end else begin
          if (gain !== gain_due[0]) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("chk: gain expected %0d actual %0d", gain_due[0], gain);
          end
          void'(gain_due.pop_front());
        end
      end
      // Shadow register writes; an index out of range is dropped
      if (wr_en) begin
        case (wr_index)
          REG_ATTACK:  attack_q  <= wr_data;
          REG_DECAY:   decay_q   <= wr_data;
          REG_RELEASE: release_q <= wr_data;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for adsr_envelope_level: drives directed and random beats through
// several register settings; checking is in adsr_envelope_level_chk. Uses aelv_pkg.
module tb;
  import aelv_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;   // no register at this index
  localparam int         LIMIT    = 400000;
  localparam int         TOP      = 24'hFFFFFF;

  logic             clk = 0, rst = 1, start = 0, wr_en = 0;
  logic [23:0]      sample_index = '0, note_len = '0;
  logic [1:0]       wr_index = '0;
  logic [REG_W-1:0] wr_data = '0;
  logic             busy, gain_valid;
  logic [Q_W-1:0]   gain;
  int               fails, pending, cycles = 0;
  longint           atk, dcy, rls;

  always #5 clk = ~clk;

  adsr_envelope_level dut (.*);
  adsr_envelope_level_chk chk (.*);

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [23:0] clamp24(longint v);
    return (v < 0) ? 24'd0 : (v > TOP) ? 24'(TOP) : 24'(v);
  endfunction

  // Send one beat, then a random gap (mostly none, a few long)
  task automatic send(longint x, longint l);
    start <= 1; sample_index <= clamp24(x); note_len <= clamp24(l);
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // Let the pipeline drain, then load all three lengths in one burst
  task automatic load_lengths(longint a, longint d, longint r);
    start <= 0;
    wait (pending == 0);
    repeat (12) @(posedge clk);
    atk = a; dcy = d; rls = r;
    wr_en <= 1;
    wr_index <= REG_ATTACK;  wr_data <= 24'(a); @(posedge clk);
    wr_index <= REG_DECAY;   wr_data <= 24'(d); @(posedge clk);
    wr_index <= REG_RELEASE; wr_data <= 24'(r); @(posedge clk);
    wr_index <= REG_NONE;    wr_data <= 24'($urandom); @(posedge clk);
    wr_en <= 0;
    @(posedge clk);
  endtask

  // One random beat shaped around the current phase boundaries
  task automatic random_beat();
    longint l, x;
    l = $urandom_range(0, 3) == 0 ? longint'($urandom) & TOP : atk + dcy + rls +
        $urandom_range(0, 200);
    case ($urandom_range(0, 5))
      0: x = longint'($urandom) & TOP;
      1: x = (atk == 0) ? 0 : $urandom_range(0, 32'(atk));
      2: x = atk + ((dcy == 0) ? 0 : $urandom_range(0, 32'(dcy)));
      3: x = l - rls + $urandom_range(0, 32'(rls) + 3);
      4: x = atk + dcy + $urandom_range(0, 3) - 1;
      default: x = l - rls + $urandom_range(0, 4) - 2;
    endcase
    send(x, l);
  endtask

  initial begin
    longint sets[7][3];
    sets = '{'{0, 0, 0}, '{TOP, TOP, TOP}, '{1, 1, 1}, '{40, 25, 60},
             '{3, 0, 17}, '{0, 9, 0}, '{500, 300, 1000}};
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: reset lengths, extremes, every phase and the saturation cases
    send(0, 0); send(TOP, TOP); send(TOP, 0);
    load_lengths(10, 10, 10);
    send(0, 100); send(9, 100); send(10, 100); send(19, 100); send(20, 100);
    send(89, 100); send(90, 100); send(95, 100); send(99, 100); send(100, 100);
    send(TOP, 100); send(25, 5); send(0, 3); send(20, 0);
    load_lengths(TOP, TOP, TOP);
    send(TOP - 1, TOP); send(TOP, TOP); send(0, 0); send(TOP, 0);
    load_lengths(0, 0, 0);
    send(5, 5); send(5, 6); send(TOP, TOP);

    // Random phases over several length settings
    for (int s = 0; s < 9; s++) begin
      if (s < 7) load_lengths(sets[s][0], sets[s][1], sets[s][2]);
      else load_lengths($urandom & TOP, $urandom & TOP, $urandom & TOP);
      for (int i = 0; i < 190; i++) begin
        random_beat();
        // Hold off once mid-phase until every result is back
        if (s == 3 && i == 90) begin
          start <= 0;
          wait (pending == 0);
          @(posedge clk);
        end
      end
    end

    start <= 0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/aelv_pkg.sv
hw/rtl/aelv_phase.sv
hw/rtl/aelv_div_step.sv
hw/rtl/adsr_envelope_level.sv
sim/adsr_envelope_level_chk.sv
sim/tb.sv
